// ===== design/bswa_pkg.sv =====
package bswa_pkg;

    localparam int NumBinsDefault = 64;

    localparam int SumW    = 64;
    localparam int SignW   = 48;
    localparam int CountW  = 32;
    localparam int MoveW   = 64;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_ACCEPT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] REG_MU    = 2'd0;
    localparam logic [1:0] REG_U     = 2'd1;
    localparam logic [1:0] REG_SITES = 2'd2;

    // packed layout of one bin word in the main memory
    typedef struct packed {
        logic signed [SumW-1:0]  hub;
        logic signed [SumW-1:0]  gc;
        logic signed [SumW-1:0]  ph;
        logic signed [SumW-1:0]  dens;
        logic signed [SumW-1:0]  dbl;
        logic signed [SignW-1:0] sgn;
        logic [CountW-1:0]       cnt;
    } bin_sums_t;

    typedef struct packed {
        logic [MoveW-1:0] acc;
        logic [MoveW-1:0] att;
    } bin_moves_t;

    localparam int SumsW  = $bits(bin_sums_t);
    localparam int MovesW = $bits(bin_moves_t);

endpackage

// ===== design/bswa_ram.sv =====
module bswa_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/bswa_divider.sv =====
module bswa_divider
    import bswa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SumW-1:0]   rem0,
    input  logic [SumW-1:0]   num,
    input  logic [SumW-1:0]   den,
    output logic              done,
    output logic [SumW-1:0]   quo
);

    // one quotient bit per cycle, unsigned restoring
    // rem0 extends the dividend above num and must be below den
    logic [SumW-1:0]  rem_reg, rem_next;
    logic [SumW-1:0]  q_reg, q_next;
    logic [SumW-1:0]  d_reg, d_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [SumW:0]    trial;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[SumW-1]} - {1'b0, d_reg};
        if (start)
        begin
            rem_next = rem0;
            q_next   = num;
            d_next   = den;
            cnt_next = 7'(SumW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[SumW])
            begin
                rem_next = trial[SumW-1:0];
                q_next   = {q_reg[SumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[SumW-2:0], q_reg[SumW-1]};
                q_next   = {q_reg[SumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ===== design/binned_sign_weighted_accumulator.sv =====
// channel   | direction | signals
// ----------+-----------+------------------------------------------------
// command   | in        | start, busy, operation .. attempted_moves
// result    | out       | result_valid, status .. acceptance_ratio
// config    | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// add and move items pass through memory read, read data and energy variants,
// sign products, a spare stage, write back and output before the strobe.
// read items run seven 64-step divisions on one shared bit-serial divider;
// an empty bin runs only the ratio division. a rejected word goes straight
// to the output stage. after reset a clearing pass writes zero to every bin,
// with busy high. busy stays high until the result strobe.
// the receiver cannot stall: result_valid is high for one cycle per item.
module binned_sign_weighted_accumulator
    import bswa_pkg::*;
#(
    parameter int NUM_BINS = NumBinsDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          operation,
    input  logic [5:0]          bin_index,
    input  logic signed [31:0]  energy,
    input  logic [27:0]         density,
    input  logic [27:0]         doublon,
    input  logic signed [15:0]  weight_sign,
    input  logic [31:0]         accepted_moves,
    input  logic [31:0]         attempted_moves,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                result_valid,
    output logic                status,
    output logic signed [31:0]  hub_energy_avg,
    output logic signed [31:0]  gc_energy_avg,
    output logic signed [31:0]  ph_energy_avg,
    output logic signed [31:0]  density_avg,
    output logic signed [31:0]  doublon_avg,
    output logic signed [15:0]  sign_avg,
    output logic [16:0]         acceptance_ratio
);

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_M1    = 4'd3;
    localparam logic [3:0] ST_M2    = 4'd4;
    localparam logic [3:0] ST_M3    = 4'd5;
    localparam logic [3:0] ST_WB    = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_DWAIT = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;

    // configuration registers
    logic signed [31:0] mu_reg, u_reg;
    logic [12:0]        sites_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg    <= '0;
            u_reg     <= '0;
            sites_reg <= 13'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MU:    mu_reg    <= cfg_data;
                REG_U:     u_reg     <= cfg_data;
                REG_SITES: sites_reg <= cfg_data[12:0];
                default:   ;
            endcase
        end
    end

    // latched command word
    logic [1:0]         op_reg;
    logic [AW-1:0]      addr_reg;
    logic signed [31:0] e_reg;
    logic [27:0]        n_reg, d_reg;
    logic signed [15:0] s_reg;
    logic [31:0]        am_reg, tm_reg;
    logic               bad_reg;

    logic accept;
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    logic bad_cmd;
    always_comb
    begin
        bad_cmd = (operation != OP_SAMPLE) && (operation != OP_ACCEPT)
                  && (operation != OP_READ);
        if (32'(bin_index) >= 32'(NUM_BINS))
        begin
            bad_cmd = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            addr_reg <= AW'(bin_index);
            e_reg    <= energy;
            n_reg    <= density;
            d_reg    <= doublon;
            s_reg    <= weight_sign;
            am_reg   <= accepted_moves;
            tm_reg   <= attempted_moves;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_reg <= 1'b0;
        end
        else if (accept)
        begin
            bad_reg <= bad_cmd;
        end
    end

    // bin memories
    logic [AW-1:0]     waddr;
    bin_sums_t         sums_w, sums_r;
    bin_moves_t        moves_w, moves_r;
    logic              we_sums, we_moves;
    logic [AW-1:0]     clr_reg;

    bswa_ram #(.Width(SumsW), .Depth(NUM_BINS)) u_sums (
        .clk   (clk),
        .we    (we_sums),
        .waddr (waddr),
        .wdata (sums_w),
        .raddr (addr_reg),
        .rdata (sums_r)
    );

    bswa_ram #(.Width(MovesW), .Depth(NUM_BINS)) u_moves (
        .clk   (clk),
        .we    (we_moves),
        .waddr (waddr),
        .wdata (moves_w),
        .raddr (addr_reg),
        .rdata (moves_r)
    );

    // held copy of the bin words
    bin_sums_t  sums_reg;
    bin_moves_t moves_reg;

    // multiply stages
    logic signed [63:0] mu_n_reg, u_n_reg, u_s_reg;
    logic signed [63:0] egc_reg, eph_reg;
    logic signed [63:0] t_hub_reg, t_gc_reg, t_ph_reg, t_n_reg, t_d_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD)
        begin
            mu_n_reg  <= 64'(mu_reg) * $signed({36'd0, n_reg});
            u_n_reg   <= 64'(u_reg) * $signed({36'd0, n_reg});
            u_s_reg   <= 64'(u_reg) * $signed({51'd0, sites_reg});
        end
        if (state_reg == ST_M1)
        begin
            sums_reg  <= sums_r;
            moves_reg <= moves_r;
            egc_reg   <= 64'(e_reg) - (mu_n_reg >>> 16);
            eph_reg   <= 64'(e_reg) - (u_n_reg >>> 17) + (u_s_reg >>> 2);
        end
        if (state_reg == ST_M2)
        begin
            t_hub_reg <= 64'(e_reg) * 64'(s_reg);
            t_gc_reg  <= egc_reg * 64'(s_reg);
            t_ph_reg  <= eph_reg * 64'(s_reg);
            t_n_reg   <= $signed({36'd0, n_reg}) * 64'(s_reg);
            t_d_reg   <= $signed({36'd0, d_reg}) * 64'(s_reg);
        end
    end

    // overflow-checked sums
    logic signed [64:0] n_hub, n_gc, n_ph, n_dn, n_db;
    logic signed [48:0] n_sg;
    logic [64:0]        n_acc, n_att;
    logic               ovf_sample, ovf_moves;

    function automatic logic ovf65(input logic signed [64:0] v);
        ovf65 = v[64] != v[63];
    endfunction

    always_comb
    begin
        n_hub = 65'(sums_reg.hub) + 65'(t_hub_reg);
        n_gc  = 65'(sums_reg.gc) + 65'(t_gc_reg);
        n_ph  = 65'(sums_reg.ph) + 65'(t_ph_reg);
        n_dn  = 65'(sums_reg.dens) + 65'(t_n_reg);
        n_db  = 65'(sums_reg.dbl) + 65'(t_d_reg);
        n_sg  = 49'(sums_reg.sgn) + 49'(s_reg);
        ovf_sample = ovf65(n_hub) || ovf65(n_gc) || ovf65(n_ph) || ovf65(n_dn)
                     || ovf65(n_db) || (n_sg[48] != n_sg[47])
                     || (sums_reg.cnt == '1) || (sites_reg == 13'd0);
        n_acc = {1'b0, moves_reg.acc} + 65'(am_reg);
        n_att = {1'b0, moves_reg.att} + 65'(tm_reg);
        ovf_moves = n_acc[64] || n_att[64];
    end

    always_comb
    begin
        we_sums  = 1'b0;
        we_moves = 1'b0;
        waddr    = addr_reg;
        sums_w   = '{hub: n_hub[63:0], gc: n_gc[63:0], ph: n_ph[63:0],
                     dens: n_dn[63:0], dbl: n_db[63:0], sgn: n_sg[47:0],
                     cnt: sums_reg.cnt + 32'd1};
        moves_w  = '{acc: n_acc[63:0], att: n_att[63:0]};
        if (state_reg == ST_CLEAR)
        begin
            waddr    = clr_reg;
            sums_w   = '0;
            moves_w  = '0;
            we_sums  = 1'b1;
            we_moves = 1'b1;
        end
        else if (state_reg == ST_WB)
        begin
            we_sums  = (op_reg == OP_SAMPLE) && !ovf_sample;
            we_moves = (op_reg == OP_ACCEPT) && !ovf_moves;
        end
    end

    // division sequence: jobs 0..4 sums over sign sum, 5 sign over count,
    // 6 acceptance ratio
    logic [2:0]        job_reg, job_next;
    logic              dstart;
    logic              ddone;
    logic [63:0]       drem, dnum, dden, dquo;
    logic              dneg;
    logic signed [63:0] jnum, jden;

    bswa_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .rem0  (drem),
        .num   (dnum),
        .den   (dden),
        .done  (ddone),
        .quo   (dquo)
    );

    always_comb
    begin
        jnum = sums_reg.hub;
        jden = 64'(sums_reg.sgn);
        case (job_reg)
            3'd0:    jnum = sums_reg.hub;
            3'd1:    jnum = sums_reg.gc;
            3'd2:    jnum = sums_reg.ph;
            3'd3:    jnum = sums_reg.dens;
            3'd4:    jnum = sums_reg.dbl;
            3'd5:
            begin
                jnum = 64'(sums_reg.sgn);
                jden = $signed({32'd0, sums_reg.cnt});
            end
            default:
            begin
                jnum = $signed({moves_reg.acc[47:0], 16'd0});
                jden = moves_reg.att;
            end
        endcase
        // ratio dividend is accepted times 65536, its top bits start the remainder
        if (job_reg == 3'd6)
        begin
            drem = {48'd0, moves_reg.acc[63:48]};
            dnum = jnum;
            dden = jden;
            dneg = 1'b0;
        end
        else
        begin
            drem = '0;
            dnum = jnum[63] ? 64'(-jnum) : jnum;
            dden = jden[63] ? 64'(-jden) : jden;
            dneg = jnum[63] != jden[63];
        end
    end

    assign dstart = (state_reg == ST_DIV);

    logic empty;
    assign empty = (sums_reg.cnt == '0) || (sums_reg.sgn == '0);

    // saturate an unsigned quotient with sign to a range
    logic signed [31:0] sat32;
    logic signed [15:0] sat16;
    logic [16:0]        ratio;
    always_comb
    begin
        if (dneg)
        begin
            sat32 = (dquo > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-dquo);
            sat16 = (dquo > 64'd16384) ? -16'sd16384 : 16'(-dquo);
        end
        else
        begin
            sat32 = (dquo > 64'h7fff_ffff) ? 32'sh7fff_ffff : dquo[31:0];
            sat16 = (dquo > 64'd16384) ? 16'sd16384 : dquo[15:0];
        end
        if (moves_reg.att == '0)
        begin
            ratio = '0;
        end
        else if (moves_reg.acc >= moves_reg.att)
        begin
            ratio = 17'd65536;
        end
        else
        begin
            ratio = dquo[16:0];
        end
    end

    // result registers
    logic        rv_reg;
    logic        st_reg;
    logic [31:0] o_hub, o_gc, o_ph, o_dn, o_db;
    logic [15:0] o_sg;
    logic [16:0] o_ar;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_reg == AW'(NUM_BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            ST_IDLE:
                if (accept)
                begin
                    state_next = bad_cmd ? ST_OUT : ST_RD;
                end
            ST_RD:    state_next = ST_M1;
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_M3;
            ST_M3:
            begin
                job_next   = empty ? 3'd6 : 3'd0;
                state_next = (op_reg == OP_READ) ? ST_DIV : ST_WB;
            end
            ST_WB:    state_next = ST_OUT;
            ST_DIV:   state_next = ST_DWAIT;
            ST_DWAIT:
                if (ddone)
                begin
                    job_next   = job_reg + 3'd1;
                    state_next = (job_reg == 3'd6) ? ST_OUT : ST_DIV;
                end
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            job_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            rv_reg    <= (state_reg == ST_OUT);
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg <= 1'b0;
            o_hub  <= '0;
            o_gc   <= '0;
            o_ph   <= '0;
            o_dn   <= '0;
            o_db   <= '0;
            o_sg   <= '0;
            o_ar   <= '0;
        end
        if (state_reg == ST_OUT && bad_reg)
        begin
            st_reg <= 1'b1;
        end
        if (state_reg == ST_WB)
        begin
            st_reg <= (op_reg == OP_SAMPLE) ? ovf_sample : ovf_moves;
        end
        if (state_reg == ST_M3 && op_reg == OP_READ)
        begin
            st_reg <= empty;
        end
        if (state_reg == ST_DWAIT && ddone)
        begin
            case (job_reg)
                3'd0:    o_hub <= sat32;
                3'd1:    o_gc  <= sat32;
                3'd2:    o_ph  <= sat32;
                3'd3:    o_dn  <= sat32;
                3'd4:    o_db  <= sat32;
                3'd5:    o_sg  <= sat16;
                default: o_ar  <= ratio;
            endcase
        end
    end

    assign result_valid     = rv_reg;
    assign status           = st_reg;
    assign hub_energy_avg   = o_hub;
    assign gc_energy_avg    = o_gc;
    assign ph_energy_avg    = o_ph;
    assign density_avg      = o_dn;
    assign doublon_avg      = o_db;
    assign sign_avg         = o_sg;
    assign acceptance_ratio = o_ar;

    // checks
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        (we_sums && we_moves) |-> (state_reg == ST_CLEAR))
        else $error("both bin memories written outside clear");
    a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (acceptance_ratio <= 17'd65536))
        else $error("acceptance ratio out of range");

endmodule
